[hdl/ams_pkg.sv]
`timescale 1ns / 1ps

package ams_pkg;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  mach_id;
        logic [3:0]  mailbox_limit;
        logic [1:0]  lifecycle_value;
        logic [63:0] payload;
        logic [1:0]  finish_result;
        logic        upd_state;
        logic [63:0] new_state;
        logic [63:0] flt_code;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  dead_reason;
        logic [4:0]  machine_out;
        logic [1:0]  lifecycle_out;
        logic [63:0] payload_out;
        logic [63:0] state_out;
        logic        fault_valid;
        logic [63:0] fault_code_out;
        logic [3:0]  mailbox_len_out;
        logic [4:0]  ready_len_out;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic take_rd;
        logic take_chk;
        logic take_data;
        logic resp;
    } ams_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] kind;
        logic       inflight_busy;
        logic       ready_empty;
        logic       take_hit;
        logic       out_free;
    } ams_sts_t;

    localparam logic [2:0] KIND_SPAWN     = 3'd0;
    localparam logic [2:0] KIND_START     = 3'd1;
    localparam logic [2:0] KIND_SET_LC    = 3'd2;
    localparam logic [2:0] KIND_ENQUEUE   = 3'd3;
    localparam logic [2:0] KIND_TAKE      = 3'd4;
    localparam logic [2:0] KIND_FINISH    = 3'd5;
    localparam logic [2:0] KIND_SET_STATE = 3'd6;
    localparam logic [2:0] KIND_QUERY     = 3'd7;

    localparam logic [1:0] LC_CREATED = 2'd0;
    localparam logic [1:0] LC_RUNNING = 2'd1;
    localparam logic [1:0] LC_STOPPED = 2'd2;
    localparam logic [1:0] LC_FAULTED = 2'd3;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_UNKNOWN     = 3'd1;
    localparam logic [2:0] ST_NOT_RUNNING = 3'd2;
    localparam logic [2:0] ST_FULL        = 3'd3;
    localparam logic [2:0] ST_NONE_READY  = 3'd4;

    localparam logic [2:0] DR_NONE    = 3'd0;
    localparam logic [2:0] DR_UNKNOWN = 3'd1;
    localparam logic [2:0] DR_FAULTED = 3'd2;
    localparam logic [2:0] DR_STOPPED = 3'd3;
    localparam logic [2:0] DR_FULL    = 3'd4;

    localparam logic [1:0] FIN_OK    = 2'd0;
    localparam logic [1:0] FIN_STOP  = 2'd1;
    localparam logic [1:0] FIN_FAULT = 2'd2;

    // register word index (paddr[2])
    localparam logic REG_STOP_ON_FAULT = 1'b0;

endpackage

[hdl/ams_ram.sv]
`timescale 1ns / 1ps

module ams_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/ams_ctrl.sv]
`timescale 1ns / 1ps

module ams_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ams_pkg::ams_sts_t sts,
    output ams_pkg::ams_cmd_t cmd
);

    import ams_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_EXEC      = 6'b000010,
        S_TAKE_RD   = 6'b000100,
        S_TAKE_CHK  = 6'b001000,
        S_TAKE_DATA = 6'b010000,
        S_RESP      = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.kind == KIND_TAKE && !sts.inflight_busy)
                begin
                    state_next = S_TAKE_RD;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_TAKE_RD:
            begin
                cmd.take_rd = 1'b1;
                state_next  = sts.ready_empty ? S_RESP : S_TAKE_CHK;
            end
            S_TAKE_CHK:
            begin
                // stale entries loop back for the next pop
                cmd.take_chk = 1'b1;
                state_next   = sts.take_hit ? S_TAKE_DATA : S_TAKE_RD;
            end
            S_TAKE_DATA:
            begin
                cmd.take_data = 1'b1;
                state_next    = S_RESP;
            end
            S_RESP:
            begin
                cmd.resp = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/ams_datapath.sv]
`timescale 1ns / 1ps

module ams_datapath #(
    parameter int MACHINES      = 16,
    parameter int MAILBOX_DEPTH = 8,
    parameter int PAYLOAD_BITS  = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ams_pkg::ams_cmd_t  cmd,
    output ams_pkg::ams_sts_t  sts,
    input  ams_pkg::in_item_t  in_item,
    input  logic               stop_on_fault,
    output logic               out_valid,
    input  logic               out_ready,
    output ams_pkg::out_item_t out_item
);

    import ams_pkg::*;

    localparam int SW     = $clog2(MACHINES);
    localparam int MCW    = $clog2(MACHINES + 1);
    localparam int HW     = (MAILBOX_DEPTH > 1) ? $clog2(MAILBOX_DEPTH) : 1;
    localparam int CW     = $clog2(MAILBOX_DEPTH + 1);
    localparam int MBX_N  = MACHINES * MAILBOX_DEPTH;
    localparam int MBX_AW = $clog2(MBX_N);

    in_item_t          in_reg;
    logic [MCW-1:0]    mcount_reg, mcount_next;
    logic [1:0]        lc_reg  [MACHINES];
    logic [63:0]       st_reg  [MACHINES];
    logic [HW-1:0]     hd_reg  [MACHINES];
    logic [CW-1:0]     ct_reg  [MACHINES];
    logic [CW-1:0]     cap_reg [MACHINES];
    logic              q_reg   [MACHINES];
    logic [SW-1:0]     rhead_reg, rhead_next;
    logic [MCW-1:0]    rcount_reg, rcount_next;
    logic [4:0]        inflight_reg, inflight_next;

    logic [2:0]        status_reg, status_next;
    logic [2:0]        dead_reg, dead_next;
    logic [4:0]        mach_reg, mach_next;
    logic [4:0]        target_reg, target_next;
    logic [63:0]       pay_reg, pay_next;
    logic              fvalid_reg, fvalid_next;
    logic [63:0]       fcode_reg, fcode_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    logic [4:0]        one_id;
    logic [SW-1:0]     idx;
    logic [1:0]        cur_lc;
    logic [63:0]       cur_st;
    logic [HW-1:0]     cur_hd;
    logic [CW-1:0]     cur_ct;
    logic [CW-1:0]     cur_cap;
    logic              cur_q;

    logic              lc_we, st_we, hd_we, ct_we, cap_we, q_we;
    logic [1:0]        lc_wd;
    logic [63:0]       st_wd;
    logic [HW-1:0]     hd_wd;
    logic [CW-1:0]     ct_wd;
    logic [CW-1:0]     cap_wd;
    logic              q_wd;

    logic              mb_we, mb_re;
    logic [MBX_AW-1:0] mb_waddr, mb_raddr;
    logic [PAYLOAD_BITS-1:0] mb_rdata;
    logic              fifo_we;
    logic [SW-1:0]     fifo_waddr;
    logic [4:0]        fifo_rdata;

    logic              do_sched;
    logic [1:0]        sched_lc;
    logic              sched_nz;
    logic [31:0]       slot_sum, slot, tail_sum;

    function automatic logic known(input logic [4:0] id, input logic [MCW-1:0] cnt);
        return id != 5'd0 && 32'(id) <= 32'(cnt) && 32'(id) <= MACHINES;
    endfunction

    // one table index serves read and write of the item in flight
    always_comb
    begin
        if (cmd.take_chk)
        begin
            one_id = fifo_rdata;
        end
        else if (cmd.resp)
        begin
            one_id = target_reg;
        end
        else if (in_reg.kind == KIND_FINISH)
        begin
            one_id = inflight_reg;
        end
        else
        begin
            one_id = in_reg.mach_id;
        end
        if (cmd.exec && in_reg.kind == KIND_SPAWN)
        begin
            idx = SW'(mcount_reg);
        end
        else
        begin
            idx = SW'(32'(one_id) - 32'd1);
        end
    end

    assign cur_lc  = lc_reg[idx];
    assign cur_st  = st_reg[idx];
    assign cur_hd  = hd_reg[idx];
    assign cur_ct  = ct_reg[idx];
    assign cur_cap = cap_reg[idx];
    assign cur_q   = q_reg[idx];

    assign mb_re    = cmd.take_chk;
    assign slot_sum = 32'(cur_hd) + 32'(cur_ct);
    assign slot     = (slot_sum >= 32'(cur_cap)) ? slot_sum - 32'(cur_cap) : slot_sum;
    assign tail_sum = 32'(rhead_reg) + 32'(rcount_reg);

    always_comb
    begin
        lc_we  = 1'b0;  lc_wd  = cur_lc;
        st_we  = 1'b0;  st_wd  = cur_st;
        hd_we  = 1'b0;  hd_wd  = cur_hd;
        ct_we  = 1'b0;  ct_wd  = cur_ct;
        cap_we = 1'b0;  cap_wd = cur_cap;
        q_we   = 1'b0;  q_wd   = 1'b0;
        mb_we    = 1'b0;
        mb_waddr = MBX_AW'(32'(idx) * MAILBOX_DEPTH + slot);
        mb_raddr = MBX_AW'(32'(idx) * MAILBOX_DEPTH + 32'(cur_hd));
        fifo_we    = 1'b0;
        fifo_waddr = SW'((tail_sum >= MACHINES) ? tail_sum - MACHINES : tail_sum);
        mcount_next   = mcount_reg;
        rhead_next    = rhead_reg;
        rcount_next   = rcount_reg;
        inflight_next = inflight_reg;
        status_next   = status_reg;
        dead_next     = dead_reg;
        mach_next     = mach_reg;
        target_next   = target_reg;
        pay_next      = pay_reg;
        fvalid_next   = fvalid_reg;
        fcode_next    = fcode_reg;
        do_sched      = 1'b0;
        sched_lc      = cur_lc;
        sched_nz      = cur_ct != '0;

        if (cmd.exec)
        begin
            status_next = ST_OK;
            dead_next   = DR_NONE;
            mach_next   = 5'd0;
            target_next = in_reg.mach_id;
            pay_next    = 64'd0;
            fvalid_next = 1'b0;
            fcode_next  = 64'd0;
            case (in_reg.kind)
                KIND_SPAWN:
                begin
                    target_next = 5'd0;
                    if (32'(mcount_reg) >= MACHINES)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        if (in_reg.mailbox_limit == 4'd0)
                        begin
                            cap_wd = CW'(1);
                        end
                        else if (32'(in_reg.mailbox_limit) > MAILBOX_DEPTH)
                        begin
                            cap_wd = CW'(MAILBOX_DEPTH);
                        end
                        else
                        begin
                            cap_wd = CW'(in_reg.mailbox_limit);
                        end
                        cap_we = 1'b1;
                        hd_we  = 1'b1;  hd_wd = '0;
                        ct_we  = 1'b1;  ct_wd = '0;
                        q_we   = 1'b1;
                        lc_we  = 1'b1;  lc_wd = LC_CREATED;
                        st_we  = 1'b1;  st_wd = 64'd0;
                        mcount_next = mcount_reg + MCW'(1);
                        mach_next   = 5'(32'(mcount_reg) + 32'd1);
                        target_next = 5'(32'(mcount_reg) + 32'd1);
                    end
                end
                KIND_TAKE:
                begin
                    target_next = 5'd0;
                    status_next = ST_NONE_READY;
                end
                KIND_FINISH:
                begin
                    if (!known(inflight_reg, mcount_reg))
                    begin
                        inflight_next = 5'd0;
                        target_next   = 5'd0;
                        status_next   = ST_NONE_READY;
                    end
                    else
                    begin
                        target_next = inflight_reg;
                        mach_next   = inflight_reg;
                        case (in_reg.finish_result)
                            FIN_OK:
                            begin
                                st_we = in_reg.upd_state;
                                st_wd = in_reg.new_state;
                            end
                            FIN_STOP:
                            begin
                                lc_we = 1'b1;
                                lc_wd = LC_STOPPED;
                            end
                            FIN_FAULT:
                            begin
                                lc_we       = 1'b1;
                                lc_wd       = stop_on_fault ? LC_STOPPED : LC_FAULTED;
                                fvalid_next = 1'b1;
                                fcode_next  = in_reg.flt_code;
                            end
                            default:
                            begin
                                st_we = 1'b0;
                            end
                        endcase
                        do_sched      = 1'b1;
                        sched_lc      = lc_wd;
                        inflight_next = 5'd0;
                    end
                end
                default:
                begin
                    if (!known(in_reg.mach_id, mcount_reg))
                    begin
                        status_next = ST_UNKNOWN;
                        if (in_reg.kind == KIND_ENQUEUE)
                        begin
                            dead_next = DR_UNKNOWN;
                        end
                    end
                    else
                    begin
                        case (in_reg.kind)
                            KIND_START:
                            begin
                                if (cur_lc != LC_CREATED)
                                begin
                                    status_next = ST_NOT_RUNNING;
                                end
                                else
                                begin
                                    lc_we    = 1'b1;
                                    lc_wd    = LC_RUNNING;
                                    do_sched = 1'b1;
                                    sched_lc = LC_RUNNING;
                                end
                            end
                            KIND_SET_LC:
                            begin
                                lc_we = 1'b1;
                                lc_wd = in_reg.lifecycle_value;
                            end
                            KIND_ENQUEUE:
                            begin
                                if (cur_lc == LC_FAULTED)
                                begin
                                    status_next = ST_NOT_RUNNING;
                                    dead_next   = DR_FAULTED;
                                end
                                else if (cur_lc == LC_STOPPED)
                                begin
                                    status_next = ST_NOT_RUNNING;
                                    dead_next   = DR_STOPPED;
                                end
                                else if (cur_ct >= cur_cap)
                                begin
                                    status_next = ST_FULL;
                                    dead_next   = DR_FULL;
                                end
                                else
                                begin
                                    mb_we    = 1'b1;
                                    ct_we    = 1'b1;
                                    ct_wd    = cur_ct + CW'(1);
                                    do_sched = 1'b1;
                                    sched_nz = 1'b1;
                                end
                            end
                            KIND_SET_STATE:
                            begin
                                st_we = 1'b1;
                                st_wd = in_reg.new_state;
                            end
                            default:
                            begin
                                st_we = 1'b0;
                            end
                        endcase
                    end
                end
            endcase
            if (do_sched && sched_lc == LC_RUNNING && sched_nz && !cur_q)
            begin
                if (32'(rcount_reg) >= MACHINES)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    fifo_we     = 1'b1;
                    q_we        = 1'b1;
                    q_wd        = 1'b1;
                    rcount_next = rcount_reg + MCW'(1);
                end
            end
        end

        if (cmd.take_chk)
        begin
            rhead_next  = (32'(rhead_reg) + 32'd1 >= MACHINES) ? '0 : rhead_reg + SW'(1);
            rcount_next = rcount_reg - MCW'(1);
            if (known(fifo_rdata, mcount_reg))
            begin
                q_we = 1'b1;
                if (cur_lc == LC_RUNNING && cur_ct != '0)
                begin
                    hd_we = 1'b1;
                    hd_wd = (32'(cur_hd) + 32'd1 >= 32'(cur_cap)) ? '0 : cur_hd + HW'(1);
                    ct_we = 1'b1;
                    ct_wd = cur_ct - CW'(1);
                    inflight_next = fifo_rdata;
                    mach_next     = fifo_rdata;
                    target_next   = fifo_rdata;
                    status_next   = ST_OK;
                end
            end
        end

        if (cmd.take_data)
        begin
            pay_next = 64'(mb_rdata);
        end
    end

    assign sts.kind          = in_reg.kind;
    assign sts.inflight_busy = inflight_reg != 5'd0;
    assign sts.ready_empty   = rcount_reg == '0;
    assign sts.take_hit      = known(fifo_rdata, mcount_reg) && cur_lc == LC_RUNNING
                               && cur_ct != '0;
    assign sts.out_free      = !out_valid_reg || out_ready;

    always_comb
    begin
        out_next                 = out_reg;
        out_valid_next           = out_valid_reg && !out_ready;
        if (cmd.resp)
        begin
            out_valid_next           = 1'b1;
            out_next.status          = status_reg;
            out_next.dead_reason     = dead_reg;
            out_next.machine_out     = mach_reg;
            out_next.payload_out     = pay_reg;
            out_next.fault_valid     = fvalid_reg;
            out_next.fault_code_out  = fcode_reg;
            out_next.ready_len_out   = 5'(rcount_reg);
            if (known(target_reg, mcount_reg))
            begin
                out_next.lifecycle_out   = cur_lc;
                out_next.state_out       = cur_st;
                out_next.mailbox_len_out = 4'(cur_ct);
            end
            else
            begin
                out_next.lifecycle_out   = LC_STOPPED;
                out_next.state_out       = 64'd0;
                out_next.mailbox_len_out = 4'd0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= in_item;
        end
        status_reg <= status_next;
        dead_reg   <= dead_next;
        mach_reg   <= mach_next;
        target_reg <= target_next;
        pay_reg    <= pay_next;
        fvalid_reg <= fvalid_next;
        fcode_reg  <= fcode_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcount_reg    <= '0;
            rhead_reg     <= '0;
            rcount_reg    <= '0;
            inflight_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MACHINES; i++)
            begin
                lc_reg[i]  <= LC_STOPPED;
                st_reg[i]  <= 64'd0;
                hd_reg[i]  <= '0;
                ct_reg[i]  <= '0;
                cap_reg[i] <= '0;
                q_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            mcount_reg    <= mcount_next;
            rhead_reg     <= rhead_next;
            rcount_reg    <= rcount_next;
            inflight_reg  <= inflight_next;
            out_valid_reg <= out_valid_next;
            if (lc_we)
            begin
                lc_reg[idx] <= lc_wd;
            end
            if (st_we)
            begin
                st_reg[idx] <= st_wd;
            end
            if (hd_we)
            begin
                hd_reg[idx] <= hd_wd;
            end
            if (ct_we)
            begin
                ct_reg[idx] <= ct_wd;
            end
            if (cap_we)
            begin
                cap_reg[idx] <= cap_wd;
            end
            if (q_we)
            begin
                q_reg[idx] <= q_wd;
            end
        end
    end

    ams_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (MBX_N)
    ) u_mailbox_ram (
        .clk   (clk),
        .we    (mb_we),
        .waddr (mb_waddr),
        .wdata (in_reg.payload[PAYLOAD_BITS-1:0]),
        .re    (mb_re),
        .raddr (mb_raddr),
        .rdata (mb_rdata)
    );

    ams_ram #(
        .WIDTH (5),
        .DEPTH (MACHINES)
    ) u_ready_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (one_id),
        .re    (cmd.take_rd),
        .raddr (rhead_reg),
        .rdata (fifo_rdata)
    );

endmodule

[hdl/actor_mailbox_scheduler.sv]
`timescale 1ns / 1ps

// Mailbox scheduler for numbered machines. One request is handled at a time:
// accept, execute, then the result is loaded into the output register once
// that register is free. A dispatch take walks the ready FIFO in RAM, each
// popped entry taking a registered RAM read and then a table check, and on a
// hit ends with a mailbox RAM read. A new request is accepted while the
// previous result is still waiting on the output side. The stop-on-fault
// register lives at byte address 0 (bit 0: 1 stops a faulting machine, 0
// marks it faulted).
module actor_mailbox_scheduler #(
    parameter int MACHINES      = 16,
    parameter int MAILBOX_DEPTH = 8,
    parameter int PAYLOAD_BITS  = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ams_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output ams_pkg::out_item_t out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    import ams_pkg::*;

    ams_cmd_t cmd;
    ams_sts_t sts;
    logic     stop_on_fault_reg, stop_on_fault_next;

    assign pready = 1'b1;

    always_comb
    begin
        stop_on_fault_next = stop_on_fault_reg;
        if (psel && penable && pwrite && paddr[2] == REG_STOP_ON_FAULT)
        begin
            stop_on_fault_next = pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_STOP_ON_FAULT) ? {31'd0, stop_on_fault_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_on_fault_reg <= 1'b0;
        end
        else
        begin
            stop_on_fault_reg <= stop_on_fault_next;
        end
    end

    ams_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ams_datapath #(
        .MACHINES      (MACHINES),
        .MAILBOX_DEPTH (MAILBOX_DEPTH),
        .PAYLOAD_BITS  (PAYLOAD_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_item       (in_item),
        .stop_on_fault (stop_on_fault_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_item      (out_item)
    );

    a_none_ready_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_NONE_READY |-> out_item.machine_out == 5'd0)
        else $error("nothing-ready result carries a machine id");

    a_fault_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.fault_valid |-> out_item.status == ST_OK)
        else $error("fault reported on a failed finish");

    a_dead_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.dead_reason != DR_NONE |-> out_item.status != ST_OK)
        else $error("dead letter with ok status");

    a_ready_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(out_item.ready_len_out) <= MACHINES)
        else $error("ready queue length over capacity");

endmodule

[dv/actor_mailbox_scheduler_tb.sv]
`timescale 1ns / 1ps

module actor_mailbox_scheduler_tb;
    import ams_pkg::*;

    localparam int NMACH = 16;
    localparam int MBOX = 8;

    class sched_scoreboard;
        // shadow copy of the scheduler tables
        bit          fault_stop;
        int unsigned mcount;
        logic [1:0]  lc[NMACH];
        logic [63:0] sword[NMACH];
        logic [63:0] mstore[NMACH][MBOX];
        int unsigned mhead[NMACH];
        int unsigned mcnt[NMACH];
        int unsigned mcap[NMACH];
        bit          queued[NMACH];
        int unsigned rfifo[NMACH];
        int unsigned rhead;
        int unsigned rcnt;
        int unsigned inflight;
        out_item_t   pending[$];
        int          mismatches;
        int          checked;
        int          takes_ok;
        int          faults_seen;

        function void clear();
            mcount = 0;
            fault_stop = 0;
            for (int i = 0; i < NMACH; i++)
            begin
                lc[i] = LC_STOPPED;
                sword[i] = '0;
                mhead[i] = 0;
                mcnt[i] = 0;
                mcap[i] = 0;
                queued[i] = 0;
            end
            rhead = 0;
            rcnt = 0;
            inflight = 0;
            mismatches = 0;
            checked = 0;
            takes_ok = 0;
            faults_seen = 0;
        endfunction

        function bit known(int unsigned id);
            return id != 0 && id <= mcount;
        endfunction

        function void sched(int unsigned id);
            int unsigned s;
            s = id - 1;
            if (lc[s] == LC_RUNNING && mcnt[s] > 0 && !queued[s] && rcnt < NMACH)
            begin
                rfifo[(rhead + rcnt) % NMACH] = id;
                rcnt++;
                queued[s] = 1;
            end
        endfunction

        function void note_request(in_item_t r);
            out_item_t e;
            int unsigned id, tgt, s, slot, popped;
            e = '0;
            id = r.mach_id;
            tgt = id;
            case (r.kind)
                KIND_SPAWN:
                begin
                    tgt = 0;
                    if (mcount >= NMACH)
                        e.status = ST_FULL;
                    else
                    begin
                        s = mcount;
                        mcap[s] = (r.mailbox_limit < 1) ? 1 :
                                  (r.mailbox_limit > MBOX) ? MBOX : r.mailbox_limit;
                        mhead[s] = 0;
                        mcnt[s] = 0;
                        queued[s] = 0;
                        lc[s] = LC_CREATED;
                        sword[s] = '0;
                        mcount++;
                        e.machine_out = 5'(mcount);
                        tgt = mcount;
                    end
                end
                KIND_TAKE:
                begin
                    tgt = 0;
                    e.status = ST_NONE_READY;
                    if (inflight == 0)
                    begin
                        while (rcnt > 0)
                        begin
                            popped = rfifo[rhead];
                            rhead = (rhead + 1) % NMACH;
                            rcnt--;
                            if (!known(popped))
                                continue;
                            s = popped - 1;
                            queued[s] = 0;
                            if (lc[s] != LC_RUNNING || mcnt[s] == 0)
                                continue;
                            e.payload_out = mstore[s][mhead[s]];
                            mhead[s] = (mhead[s] + 1) % mcap[s];
                            mcnt[s]--;
                            inflight = popped;
                            e.machine_out = 5'(popped);
                            tgt = popped;
                            e.status = ST_OK;
                            takes_ok++;
                            break;
                        end
                    end
                end
                KIND_FINISH:
                begin
                    if (inflight == 0 || !known(inflight))
                    begin
                        inflight = 0;
                        tgt = 0;
                        e.status = ST_NONE_READY;
                    end
                    else
                    begin
                        tgt = inflight;
                        e.machine_out = 5'(inflight);
                        s = inflight - 1;
                        if (r.finish_result == FIN_OK)
                        begin
                            if (r.upd_state)
                                sword[s] = r.new_state;
                        end
                        else if (r.finish_result == FIN_STOP)
                            lc[s] = LC_STOPPED;
                        else if (r.finish_result == FIN_FAULT)
                        begin
                            lc[s] = fault_stop ? LC_STOPPED : LC_FAULTED;
                            e.fault_valid = 1;
                            e.fault_code_out = r.flt_code;
                            faults_seen++;
                        end
                        sched(inflight);
                        inflight = 0;
                    end
                end
                default:
                begin
                    if (!known(id))
                    begin
                        e.status = ST_UNKNOWN;
                        if (r.kind == KIND_ENQUEUE)
                            e.dead_reason = DR_UNKNOWN;
                    end
                    else
                    begin
                        s = id - 1;
                        if (r.kind == KIND_START)
                        begin
                            if (lc[s] != LC_CREATED)
                                e.status = ST_NOT_RUNNING;
                            else
                            begin
                                lc[s] = LC_RUNNING;
                                sched(id);
                            end
                        end
                        else if (r.kind == KIND_SET_LC)
                            lc[s] = r.lifecycle_value;
                        else if (r.kind == KIND_ENQUEUE)
                        begin
                            if (lc[s] == LC_FAULTED)
                            begin
                                e.status = ST_NOT_RUNNING;
                                e.dead_reason = DR_FAULTED;
                            end
                            else if (lc[s] == LC_STOPPED)
                            begin
                                e.status = ST_NOT_RUNNING;
                                e.dead_reason = DR_STOPPED;
                            end
                            else if (mcnt[s] >= mcap[s])
                            begin
                                e.status = ST_FULL;
                                e.dead_reason = DR_FULL;
                            end
                            else
                            begin
                                slot = (mhead[s] + mcnt[s]) % mcap[s];
                                mstore[s][slot] = r.payload;
                                mcnt[s]++;
                                sched(id);
                            end
                        end
                        else if (r.kind == KIND_SET_STATE)
                            sword[s] = r.new_state;
                    end
                end
            endcase
            if (known(tgt))
            begin
                s = tgt - 1;
                e.lifecycle_out = lc[s];
                e.state_out = sword[s];
                e.mailbox_len_out = 4'(mcnt[s]);
            end
            else
                e.lifecycle_out = LC_STOPPED;
            e.ready_len_out = 5'(rcnt);
            pending.push_back(e);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch #%0d at %0t", checked, $realtime);
                    $display("  exp st=%0d dr=%0d m=%0d lc=%0d pay=%h sw=%h",
                             exp.status, exp.dead_reason, exp.machine_out,
                             exp.lifecycle_out, exp.payload_out, exp.state_out);
                    $display("      fv=%0d fc=%h ml=%0d rl=%0d",
                             exp.fault_valid, exp.fault_code_out,
                             exp.mailbox_len_out, exp.ready_len_out);
                    $display("  got st=%0d dr=%0d m=%0d lc=%0d pay=%h sw=%h",
                             got.status, got.dead_reason, got.machine_out,
                             got.lifecycle_out, got.payload_out, got.state_out);
                    $display("      fv=%0d fc=%h ml=%0d rl=%0d",
                             got.fault_valid, got.fault_code_out,
                             got.mailbox_len_out, got.ready_len_out);
                end
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_ready = 0;
    out_item_t out_item;
    logic psel = 0;
    logic penable = 0;
    logic pwrite = 0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    sched_scoreboard sb;
    bit sender_bursts = 1;
    bit receiver_bursts = 1;
    bit long_hold_req = 0;
    int hold_cycles = 0;
    int requests_sent = 0;
    int policy_writes = 0;

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    actor_mailbox_scheduler u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // receiver: random stall bursts plus an optional long hold-off
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_item);
        if (long_hold_req)
        begin
            long_hold_req = 0;
            hold_cycles <= 400;
            out_ready <= 0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 0;
        end
        else if (receiver_bursts && $urandom_range(0, 9) == 0)
        begin
            hold_cycles <= $urandom_range(1, 16);
            out_ready <= 0;
        end
        else
            out_ready <= 1;
    end

    task automatic send_request(in_item_t r);
        int gap;
        if (sender_bursts && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_item <= r;
        in_valid <= 1;
        do @(posedge clk); while (!in_ready);
        sb.note_request(r);
        requests_sent++;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 0;
        while (sb.pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        // some slack before the next phase
        repeat (50) @(posedge clk);
    endtask

    task automatic write_policy(bit v);
        drain();
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= '0;
        pwdata <= {31'd0, v};
        @(posedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.fault_stop = v;
        policy_writes++;
    endtask

    function automatic in_item_t rand_item(bit well_formed);
        in_item_t r;
        int k;
        r.kind = 3'($urandom_range(0, 7));
        r.mach_id = 5'($urandom_range(0, 31));
        r.mailbox_limit = 4'($urandom_range(0, 15));
        r.lifecycle_value = 2'($urandom_range(0, 3));
        r.payload = {$urandom, $urandom};
        r.finish_result = 2'($urandom_range(0, 3));
        r.upd_state = 1'($urandom_range(0, 1));
        r.new_state = {$urandom, $urandom};
        r.flt_code = {$urandom, $urandom};
        if (well_formed)
        begin
            // mostly valid ids, favor enqueue/take/finish traffic
            k = $urandom_range(0, 99);
            r.mach_id = (sb.mcount > 0) ? 5'($urandom_range(1, sb.mcount)) : 5'd1;
            if (k < 30)
                r.kind = KIND_ENQUEUE;
            else if (k < 50)
                r.kind = KIND_TAKE;
            else if (k < 70)
                r.kind = KIND_FINISH;
            else if (k < 76)
                r.kind = KIND_START;
            else if (k < 80)
                r.kind = KIND_SET_LC;
            else if (k < 86)
                r.kind = KIND_SET_STATE;
            else if (k < 94)
                r.kind = KIND_QUERY;
            else
                r.kind = KIND_SPAWN;
            if (r.kind == KIND_SET_LC && $urandom_range(0, 1))
                r.lifecycle_value = LC_RUNNING;
            if (r.finish_result == FIN_FAULT && $urandom_range(0, 1))
                r.finish_result = FIN_OK;
        end
        return r;
    endfunction

    function automatic in_item_t mk(logic [2:0] k, logic [4:0] id);
        in_item_t r;
        r = '0;
        r.kind = k;
        r.mach_id = id;
        return r;
    endfunction

    initial
    begin
        #5_000_000;
        $display("FAIL actor_mailbox_scheduler");
        $finish;
    end

    initial
    begin
        in_item_t r;
        sb = new();
        sb.clear();
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed
        write_policy(0);
        send_request(mk(KIND_TAKE, 0));
        send_request(mk(KIND_FINISH, 0));
        send_request(mk(KIND_QUERY, 0));
        r = mk(KIND_ENQUEUE, 31);
        r.payload = '1;
        send_request(r);
        r = mk(KIND_SPAWN, 0);
        r.mailbox_limit = 0;
        send_request(r);
        r.mailbox_limit = 15;
        send_request(r);
        r.mailbox_limit = 3;
        send_request(r);
        r = mk(KIND_ENQUEUE, 1);
        r.payload = 64'hFFFF_FFFF_FFFF_FFFF;
        send_request(r);
        send_request(r);
        send_request(mk(KIND_START, 1));
        send_request(mk(KIND_START, 1));
        send_request(mk(KIND_TAKE, 0));
        send_request(mk(KIND_TAKE, 0));
        r = mk(KIND_FINISH, 0);
        r.finish_result = FIN_FAULT;
        r.flt_code = '1;
        send_request(r);
        send_request(mk(KIND_ENQUEUE, 1));
        r = mk(KIND_SET_LC, 2);
        r.lifecycle_value = LC_STOPPED;
        send_request(r);
        send_request(mk(KIND_ENQUEUE, 2));
        r = mk(KIND_SET_STATE, 3);
        r.new_state = '1;
        send_request(r);
        r = mk(KIND_SET_LC, 1);
        r.lifecycle_value = LC_RUNNING;
        send_request(r);
        send_request(mk(KIND_TAKE, 0));
        r = mk(KIND_FINISH, 0);
        r.finish_result = 2'd3;
        send_request(r);
        send_request(mk(KIND_QUERY, 1));

        // random, policy changes between phases
        for (int phase = 0; phase < 4; phase++)
        begin
            write_policy(phase[0]);
            for (int i = 0; i < 220; i++)
            begin
                r = rand_item($urandom_range(0, 9) < 8);
                send_request(r);
                if (i == 100 && phase == 1)
                    long_hold_req = 1;
            end
        end
        // quiet sender then final part without idling
        drain();
        sender_bursts = 0;
        receiver_bursts = 0;
        for (int i = 0; i < 120; i++)
            send_request(rand_item(1));
        drain();

        $display("covered %0d requests, %0d dispatches, %0d faults, %0d policy writes",
                 requests_sent, sb.takes_ok, sb.faults_seen, policy_writes);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASS actor_mailbox_scheduler");
        else
            $display("FAIL actor_mailbox_scheduler");
        $finish;
    end
endmodule
